>>> rtl/fla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// fla_pkg: widths, limits and status codes of the filter lock arbiter.
// No dependencies; used by filter_lock_arbiter_top.
package fla_pkg;

    localparam int CFG_W          = 5;   // thread_count register width
    localparam int THREAD_W       = 4;   // thread id field width
    localparam int STATUS_W       = 3;
    localparam int LEVEL_OUT_W    = 4;
    localparam int ID_LIMIT       = 16;  // ids that the thread field can carry
    localparam int COUNT_LIMIT    = 31;  // largest value of thread_count
    localparam int DEF_MAX_THREADS = 16;
    localparam int CFG_RESET      = 16;

    localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADVANCED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

endpackage
`default_nettype wire

>>> rtl/filter_lock_arbiter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// filter_lock_arbiter_top: filter (Peterson) lock arbiter, one request per item.
// Depends on fla_pkg.
//
//  channel | ports                         | payload
//  --------+-------------------------------+------------------------------------
//  request | s_tvalid s_tready s_tdata s_tuser | tuser: op; tdata: thread
//  result  | m_tvalid m_tready m_tdata     | tdata: status, level_now
//  config  | cfg_we cfg_wdata              | thread_count
//
// A request passes S_LOOK and S_OUT from acceptance until ready returns. An acquire
// of a counted, ungranted thread above level 0 (n_reg > 1) passes S_RESOLVE; if it is
// the victim of its level, a single compare unit scans thread levels, one thread a
// cycle, up to the first one at or above it or the last counted thread (16 at most).
// Ready is high in idle; a result not yet taken stalls the next one in S_OUT.
// Synchronous active-low reset clears levels, victims and held marks at once.
module filter_lock_arbiter_top #(
    parameter int MAX_THREADS = fla_pkg::DEF_MAX_THREADS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [fla_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [3:0] thread, [7:4] zero
    input  wire logic                        s_tuser,   // [0] op
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata    // [2:0] status, [6:3] level_now
);
    import fla_pkg::*;

    localparam int NT   = (MAX_THREADS < ID_LIMIT) ? MAX_THREADS : ID_LIMIT;
    localparam int NMAX = (MAX_THREADS < COUNT_LIMIT) ? MAX_THREADS : COUNT_LIMIT;
    localparam int TW   = $clog2(NT);
    localparam int LW   = $clog2(NMAX);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOOK    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_RESOLVE = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    count_reg;
    logic [LW-1:0]       level_reg [NT];
    logic [TW-1:0]       victim_reg [NMAX];
    logic [NT-1:0]       hold_reg;

    logic                op_reg;
    logic [THREAD_W-1:0] thread_reg;
    logic [CFG_W-1:0]    n_reg, n_eff;
    logic [TW-1:0]       last_reg, last_calc;
    logic [TW-1:0]       scan_reg, scan_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic                blocked_reg, blocked_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [LW-1:0]       lvl_out_reg, lvl_out_next;
    logic                m_valid_reg;
    logic [7:0]          m_data_reg;

    // write strobes into the state arrays
    logic                lvl_we, vic_we, hold_we, hold_wd;
    logic [LW-1:0]       lvl_wd, vic_wa;

    logic [TW-1:0]       t_idx;
    logic [LW-1:0]       lvl_cur;
    logic                out_free, accept;
    logic                scan_hit;

    assign t_idx    = thread_reg[TW-1:0];
    assign lvl_cur  = level_reg[t_idx];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // effective count clamped to 1..NMAX
    always_comb begin
        if (count_reg == '0) begin
            n_eff = CFG_W'(1);
        end else if (count_reg > CFG_W'(NMAX)) begin
            n_eff = CFG_W'(NMAX);
        end else begin
            n_eff = count_reg;
        end
        // last thread worth scanning; ids at or above NT never leave level 0
        if (n_eff > CFG_W'(NT)) begin
            last_calc = TW'(NT - 1);
        end else begin
            last_calc = TW'(n_eff - CFG_W'(1));
        end
    end

    // shared compare unit of the scan
    assign scan_hit = (level_reg[scan_reg] >= lvl_reg) && (scan_reg != t_idx);

    always_comb begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        lvl_next     = lvl_reg;
        blocked_next = blocked_reg;
        status_next  = status_reg;
        lvl_out_next = lvl_out_reg;
        lvl_we       = 1'b0;
        lvl_wd       = '0;
        vic_we       = 1'b0;
        vic_wa       = '0;
        hold_we      = 1'b0;
        hold_wd      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                lvl_next     = lvl_cur;
                blocked_next = 1'b0;
                scan_next    = '0;
                state_next   = S_OUT;
                if ({1'b0, thread_reg} >= n_reg) begin
                    status_next  = ST_REJECTED;
                    lvl_out_next = '0;
                end else if (op_reg == OP_RELEASE) begin
                    lvl_we       = 1'b1;
                    lvl_wd       = '0;
                    hold_we      = 1'b1;
                    hold_wd      = 1'b0;
                    status_next  = ST_RELEASED;
                    lvl_out_next = '0;
                end else if (hold_reg[t_idx]) begin
                    status_next  = ST_GRANTED;
                    lvl_out_next = lvl_cur;
                end else if (n_reg == CFG_W'(1)) begin
                    hold_we      = 1'b1;
                    hold_wd      = 1'b1;
                    status_next  = ST_GRANTED;
                    lvl_out_next = lvl_cur;
                end else if (lvl_cur == '0) begin
                    lvl_we       = 1'b1;
                    lvl_wd       = LW'(1);
                    vic_we       = 1'b1;
                    vic_wa       = LW'(1);
                    status_next  = ST_ADVANCED;
                    lvl_out_next = LW'(1);
                end else if (victim_reg[lvl_cur] != t_idx) begin
                    state_next = S_RESOLVE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    blocked_next = 1'b1;
                    state_next   = S_RESOLVE;
                end else if (scan_reg == last_reg) begin
                    state_next = S_RESOLVE;
                end else begin
                    scan_next = scan_reg + TW'(1);
                end
            end
            S_RESOLVE: begin
                state_next = S_OUT;
                if (blocked_reg) begin
                    status_next  = ST_BLOCKED;
                    lvl_out_next = lvl_reg;
                end else if (CFG_W'(lvl_reg) >= CFG_W'(n_reg - CFG_W'(1))) begin
                    hold_we      = 1'b1;
                    hold_wd      = 1'b1;
                    status_next  = ST_GRANTED;
                    lvl_out_next = lvl_reg;
                end else begin
                    lvl_we       = 1'b1;
                    lvl_wd       = lvl_reg + LW'(1);
                    vic_we       = 1'b1;
                    vic_wa       = lvl_reg + LW'(1);
                    status_next  = ST_ADVANCED;
                    lvl_out_next = lvl_reg + LW'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CFG_W'(CFG_RESET);
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                level_reg[i] <= '0;
            end
            for (int i = 0; i < NMAX; i++) begin
                victim_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (lvl_we) begin
                level_reg[t_idx] <= lvl_wd;
            end
            if (vic_we) begin
                victim_reg[vic_wa] <= t_idx;
            end
            if (hold_we) begin
                hold_reg[t_idx] <= hold_wd;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tuser;
            thread_reg <= s_tdata[THREAD_W-1:0];
            n_reg      <= n_eff;
            last_reg   <= last_calc;
        end
        scan_reg    <= scan_next;
        lvl_reg     <= lvl_next;
        blocked_reg <= blocked_next;
        status_reg  <= status_next;
        lvl_out_reg <= lvl_out_next;
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= {1'b0, LEVEL_OUT_W'(lvl_out_reg), status_reg};
        end
    end

endmodule
`default_nettype wire

>>> verif/filter_lock_arbiter_top_tb.sv
`timescale 1ns / 1ps
// filter_lock_arbiter_top_tb: self-checking bench for the filter lock arbiter.
// Drives lock requests, predicts status and level per request, and checks each result.
// Depends on fla_pkg and filter_lock_arbiter_top.
module filter_lock_arbiter_top_tb;
    import fla_pkg::*;

    localparam int MAX_THREADS = DEF_MAX_THREADS;
    localparam int DRAIN_SLACK = 32;
    localparam int PHASE_ITEMS = 125;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [LEVEL_OUT_W-1:0] level;
    } lock_result_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [3:0] thread, [7:4] zero
    logic             s_tuser;   // [0] op
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [2:0] status, [6:3] level_now

    // lock model state
    logic [CFG_W-1:0]    count_reg;
    logic [THREAD_W-1:0] level_of  [MAX_THREADS];
    logic [THREAD_W-1:0] victim_of [MAX_THREADS];
    logic                holding   [MAX_THREADS];

    lock_result_t expected_results[$];
    int error_count  = 0;
    int hold_cycles  = 0;
    int crowd_base   = 0;
    int crowd_size   = MAX_THREADS;
    bit sink_quiet   = 1'b0;
    bit source_quiet = 1'b0;

    filter_lock_arbiter_top #(
        .MAX_THREADS(MAX_THREADS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int active_count();
        int n;
        n = count_reg;
        if (n < 1) n = 1;
        if (n > MAX_THREADS) n = MAX_THREADS;
        return n;
    endfunction

    // victim of its level and someone else (below the count) at or above it
    function automatic bit contested(int t, int lv, int n);
        if (victim_of[lv] != t) return 1'b0;
        for (int j = 0; j < n; j++) begin
            if (j != t && level_of[j] >= lv) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic lock_result_t step_lock(logic op, int t);
        lock_result_t r;
        int n;
        int lv;
        n = active_count();
        r.level = '0;
        if (t >= n) begin
            r.status = ST_REJECTED;
            return r;
        end
        if (op == OP_RELEASE) begin
            level_of[t] = '0;
            holding[t]  = 1'b0;
            r.status    = ST_RELEASED;
        end else if (holding[t]) begin
            r.status = ST_GRANTED;
        end else if (n == 1) begin
            holding[t] = 1'b1;
            r.status   = ST_GRANTED;
        end else begin
            lv = level_of[t];
            if (lv == 0) begin
                level_of[t]  = THREAD_W'(1);
                victim_of[1] = THREAD_W'(t);
                r.status     = ST_ADVANCED;
            end else if (contested(t, lv, n)) begin
                r.status = ST_BLOCKED;
            end else if (lv >= n - 1) begin
                holding[t] = 1'b1;
                r.status   = ST_GRANTED;
            end else begin
                level_of[t]       = THREAD_W'(lv + 1);
                victim_of[lv + 1] = THREAD_W'(t);
                r.status          = ST_ADVANCED;
            end
        end
        r.level = level_of[t];
        return r;
    endfunction

    // valid stays high after acceptance unless a gap follows
    task automatic send_request(input logic op, input int t);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= 8'(t);
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(step_lock(op, t));
        gap = source_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_thread_count(input int value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        count_reg = CFG_W'(value);
    endtask

    // mostly acquire loops and releases within a small crowd of threads, some noise
    task automatic send_lock_traffic();
        int n;
        int t;
        int r;
        n = active_count();
        r = $urandom_range(99);
        if (r < 12) begin
            send_request(logic'($urandom_range(1)), $urandom_range(ID_LIMIT - 1));
        end else begin
            if (crowd_base + crowd_size > n)
                t = $urandom_range(n - 1);
            else
                t = crowd_base + $urandom_range(crowd_size - 1);
            if (r < 24)
                send_request(OP_RELEASE, t);
            else if (holding[t] && $urandom_range(4) != 0)
                send_request(OP_RELEASE, t);
            else
                send_request(OP_ACQUIRE, t);
        end
    endtask

    task automatic test_release_idle();
        send_request(OP_RELEASE, 0);
        send_request(OP_ACQUIRE, ID_LIMIT - 1);
        send_request(OP_ACQUIRE, ID_LIMIT - 1);
        send_request(OP_RELEASE, ID_LIMIT - 1);
    endtask

    task automatic test_single_thread();
        write_thread_count(0);   // clamps to one thread
        send_request(OP_ACQUIRE, 0);
        send_request(OP_ACQUIRE, 0);
        send_request(OP_ACQUIRE, 1);
        send_request(OP_RELEASE, ID_LIMIT - 1);
        send_request(OP_RELEASE, 0);
        write_thread_count(1);
        send_request(OP_ACQUIRE, 0);
        send_request(OP_RELEASE, 0);
    endtask

    task automatic test_two_threads();
        write_thread_count(2);
        send_request(OP_ACQUIRE, 0);
        send_request(OP_ACQUIRE, 1);
        send_request(OP_ACQUIRE, 1);
        send_request(OP_ACQUIRE, 0);
        send_request(OP_ACQUIRE, 1);
        send_request(OP_RELEASE, 0);
        send_request(OP_ACQUIRE, 1);
        send_request(OP_RELEASE, 1);
    endtask

    task automatic test_count_lowered();
        write_thread_count(COUNT_LIMIT);
        send_request(OP_ACQUIRE, 0);
        send_request(OP_ACQUIRE, 1);
        send_request(OP_ACQUIRE, 2);
        send_request(OP_ACQUIRE, 0);
        // threads keep their levels when the count drops under them
        write_thread_count(2);
        send_request(OP_ACQUIRE, 2);
        send_request(OP_ACQUIRE, 0);
        send_request(OP_RELEASE, 0);
        send_request(OP_RELEASE, 1);
    endtask

    task automatic test_backpressure();
        write_thread_count(CFG_RESET);
        crowd_base   = 0;
        crowd_size   = MAX_THREADS;
        hold_cycles  = 300;
        source_quiet = 1'b1;
        repeat (24) send_lock_traffic();
        source_quiet = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_phases();
        int counts[$];
        int value;
        int n;
        counts = '{16, 3, 2, 0, 31, 5, 1, 4, 16, 2, 3};
        for (int p = 0; p < 12; p++) begin
            value = (p < counts.size()) ? counts[p] : $urandom_range(COUNT_LIMIT);
            write_thread_count(value);
            n = active_count();
            crowd_size = $urandom_range(1, (n > 4) ? 4 : n);
            if ($urandom_range(3) == 0) crowd_size = n;
            crowd_base = $urandom_range(n - crowd_size);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0) begin
                    source_quiet = ($urandom_range(3) == 0);
                    sink_quiet   = ($urandom_range(3) == 0);
                end
                send_lock_traffic();
            end
        end
        source_quiet = 1'b0;
        sink_quiet   = 1'b0;
    endtask

    // result sink: random stalls, plus a long hold when requested
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!sink_quiet) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        lock_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending: status %0d level %0d",
                         $time, m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: LEVEL_OUT_W]);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[STATUS_W-1:0] !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_tdata[STATUS_W-1:0]);
                    error_count++;
                end
                if (m_tdata[STATUS_W +: LEVEL_OUT_W] !== want.level) begin
                    $display("%0t: level_now mismatch: expected %0d, actual %0d",
                             $time, want.level, m_tdata[STATUS_W +: LEVEL_OUT_W]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        count_reg = CFG_W'(CFG_RESET);
        for (int i = 0; i < MAX_THREADS; i++) begin
            level_of[i]  = '0;
            victim_of[i] = '0;
            holding[i]   = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_release_idle();
        test_single_thread();
        test_two_threads();
        test_count_lowered();
        test_backpressure();
        test_random_phases();
        wait_for_results();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
